// File: hw/rtl/tleb_pkg.sv
package tleb_pkg;

  localparam int CMD_W  = 1;
  localparam int KEY_W  = 8;
  localparam int ADDR_W = 10;
  localparam int POS_W  = 10;

  localparam logic [KEY_W-1:0] KEY_UP    = 8'd17;
  localparam logic [KEY_W-1:0] KEY_DOWN  = 8'd18;
  localparam logic [KEY_W-1:0] KEY_LEFT  = 8'd19;
  localparam logic [KEY_W-1:0] KEY_RIGHT = 8'd20;
  localparam logic [KEY_W-1:0] KEY_BACK  = 8'd8;
  localparam logic [KEY_W-1:0] NEWLINE   = 8'd10;

  localparam logic [CMD_W-1:0] CMD_KEY  = 1'b0;
  localparam logic [CMD_W-1:0] CMD_READ = 1'b1;

  localparam int HEIGHT_W = 10;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = 10'd300;
  localparam logic [HEIGHT_W-1:0] HEIGHT_BASE  = 10'd40;
  localparam int VIS_W = 7;

  // visible lines = (h - 40) / 10 + 3, signed truncation, floor of one
  function automatic logic [VIS_W-1:0] vis_line_count(input logic [HEIGHT_W-1:0] h);
    logic                  ge;
    logic [HEIGHT_W-1:0]   d;
    logic [HEIGHT_W+7:0]   prod;
    logic [VIS_W-1:0]      q;
    ge   = (h >= HEIGHT_BASE);
    d    = ge ? (h - HEIGHT_BASE) : (HEIGHT_BASE - h);
    // d / 10 as d * 205 >> 11, exact below 1029
    prod = {8'd0, d} * 18'd205;
    q    = VIS_W'(prod >> 11);
    if (ge) begin
      vis_line_count = q + 7'd3;
    end else if (q >= 7'd2) begin
      vis_line_count = 7'd1;
    end else begin
      vis_line_count = 7'd3 - q;
    end
  endfunction

endpackage

// File: hw/rtl/tleb_ifs.sv
interface tleb_in_if
  import tleb_pkg::*;
();
  logic              valid;
  logic              ready;
  logic [CMD_W-1:0]  command;
  logic [KEY_W-1:0]  key_code;
  logic [ADDR_W-1:0] read_address;

  modport source (output valid, command, key_code, read_address, input ready);
  modport sink   (input valid, command, key_code, read_address, output ready);
endinterface

interface tleb_out_if
  import tleb_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] cursor_position;
  logic [POS_W-1:0] text_length;
  logic [POS_W-1:0] top_line;
  logic [KEY_W-1:0] read_character;
  logic             insert_refused;

  modport source (output valid, cursor_position, text_length, top_line, read_character,
                  insert_refused, input ready);
  modport sink   (input valid, cursor_position, text_length, top_line, read_character,
                  insert_refused, output ready);
endinterface

// File: hw/rtl/tleb_ram.sv
module tleb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;
endmodule

// File: hw/rtl/text_line_editor_buffer_top.sv
// Line editor buffer: text store with length, cursor and top scroll line.
// Input channel in_if (valid/ready): command 0 handles key_code as an
// editing key (up, down, left, right, backspace, otherwise insert);
// command 1 reads the stored character at read_address.
// Output channel out_if: one item per input item with cursor, length,
// top line, read character and the insert-refused flag.
// APB port (psel/penable/pwrite/paddr/pwdata/prdata/pready) holds the
// window height at byte address 0; write it only while the block is idle.
// Items are handled one at a time by a sequencer around a store with
// one write port and one read port; each scan step has an address
// state and a data state. Up and down first scan the text for line
// bounds; left/right, up/down and edits that change the text end with a
// scan up to the cursor to set the top line. in_if.ready is high only
// between items. A finished item sits in the output register until taken;
// a stalled receiver holds the sequencer in its final state.
// Reset (rst_n, synchronous) clears length, cursor, top line and sets the
// height to 300. Entries at or past the length always read as zero, so no
// clearing pass over the store is needed.
module text_line_editor_buffer_top
  import tleb_pkg::*;
#(
  parameter int STORE_DEPTH = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  tleb_in_if.sink     in_if,
  tleb_out_if.source  out_if,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  localparam int AW = $clog2(STORE_DEPTH);
  localparam int CW = (AW > ADDR_W) ? AW + 1 : ADDR_W + 1;
  localparam int SW = (AW > VIS_W) ? AW + 1 : VIS_W + 1;
  localparam logic [AW-1:0] LEN_MAX = AW'(STORE_DEPTH - 1);

  localparam logic [4:0] ST_IDLE   = 5'd0;
  localparam logic [4:0] ST_RD0    = 5'd1;
  localparam logic [4:0] ST_RD1    = 5'd2;
  localparam logic [4:0] ST_UP0    = 5'd3;
  localparam logic [4:0] ST_UP1    = 5'd4;
  localparam logic [4:0] ST_UP2    = 5'd5;
  localparam logic [4:0] ST_DN0    = 5'd6;
  localparam logic [4:0] ST_DN1    = 5'd7;
  localparam logic [4:0] ST_DN2    = 5'd8;
  localparam logic [4:0] ST_DN3    = 5'd9;
  localparam logic [4:0] ST_LB_ISS = 5'd10;
  localparam logic [4:0] ST_LB_CHK = 5'd11;
  localparam logic [4:0] ST_FS_ISS = 5'd12;
  localparam logic [4:0] ST_FS_CHK = 5'd13;
  localparam logic [4:0] ST_BK_ISS = 5'd14;
  localparam logic [4:0] ST_BK_WR  = 5'd15;
  localparam logic [4:0] ST_IN_ISS = 5'd16;
  localparam logic [4:0] ST_IN_WR  = 5'd17;
  localparam logic [4:0] ST_VS0    = 5'd18;
  localparam logic [4:0] ST_VS_ISS = 5'd19;
  localparam logic [4:0] ST_VS_CHK = 5'd20;
  localparam logic [4:0] ST_VS_FIX = 5'd21;
  localparam logic [4:0] ST_DONE   = 5'd22;

  logic [4:0]          state_r, state_nxt, ret_r, ret_nxt;
  logic [AW-1:0]       p_r, p_nxt, a_r, a_nxt, col_r, col_nxt, line_r, line_nxt;
  logic [AW-1:0]       cur_r, cur_nxt, len_r, len_nxt, scr_r, scr_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt, rd_r, rd_nxt;
  logic [ADDR_W-1:0]   addr_r, addr_nxt;
  logic                ref_r, ref_nxt;
  logic [HEIGHT_W-1:0] height_r;
  logic                ov_r, ov_nxt;
  logic [POS_W-1:0]    ocur_r, ocur_nxt, olen_r, olen_nxt, otop_r, otop_nxt;
  logic [KEY_W-1:0]    ord_r, ord_nxt;
  logic                oref_r, oref_nxt;

  logic                we_c;
  logic [AW-1:0]       waddr_c, raddr_c, plen_c, span_c;
  logic [KEY_W-1:0]    wdata_c, rdata;
  logic [CW-1:0]       addr_ext;
  logic [VIS_W-1:0]    vis_c;
  logic [SW-1:0]       bottom_c;

  tleb_ram #(.WIDTH(KEY_W), .DEPTH(STORE_DEPTH)) u_store (
    .clk   (clk),
    .we    (we_c),
    .waddr (waddr_c),
    .wdata (wdata_c),
    .raddr (raddr_c),
    .rdata (rdata)
  );

  assign pready = 1'b1;
  assign prdata = (paddr[2] == 1'b0) ? {22'd0, height_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      height_r <= HEIGHT_RESET;
    end else if (psel && penable && pwrite && paddr[2] == 1'b0) begin
      height_r <= pwdata[HEIGHT_W-1:0];
    end
  end

  assign vis_c    = vis_line_count(height_r);
  assign bottom_c = SW'(scr_r) + SW'(vis_c);
  assign addr_ext = CW'(addr_r);
  assign plen_c   = a_r - AW'(1) - p_r;
  assign span_c   = p_r - a_r;

  assign in_if.ready            = (state_r == ST_IDLE);
  assign out_if.valid           = ov_r;
  assign out_if.cursor_position = ocur_r;
  assign out_if.text_length     = olen_r;
  assign out_if.top_line        = otop_r;
  assign out_if.read_character  = ord_r;
  assign out_if.insert_refused  = oref_r;

  always_comb begin
    state_nxt = state_r;
    ret_nxt   = ret_r;
    p_nxt     = p_r;
    a_nxt     = a_r;
    col_nxt   = col_r;
    line_nxt  = line_r;
    cur_nxt   = cur_r;
    len_nxt   = len_r;
    scr_nxt   = scr_r;
    key_nxt   = key_r;
    addr_nxt  = addr_r;
    rd_nxt    = rd_r;
    ref_nxt   = ref_r;
    ov_nxt    = ov_r && !out_if.ready;
    ocur_nxt  = ocur_r;
    olen_nxt  = olen_r;
    otop_nxt  = otop_r;
    ord_nxt   = ord_r;
    oref_nxt  = oref_r;
    we_c      = 1'b0;
    waddr_c   = p_r;
    wdata_c   = rdata;
    raddr_c   = p_r;

    case (state_r)
      ST_IDLE: begin
        if (in_if.valid) begin
          key_nxt  = in_if.key_code;
          addr_nxt = in_if.read_address;
          rd_nxt   = '0;
          ref_nxt  = 1'b0;
          if (in_if.command == CMD_READ) begin
            state_nxt = ST_RD0;
          end else begin
            case (in_if.key_code)
              KEY_UP:   state_nxt = ST_UP0;
              KEY_DOWN: state_nxt = ST_DN0;
              KEY_LEFT: begin
                if (cur_r != '0) cur_nxt = cur_r - AW'(1);
                state_nxt = ST_VS0;
              end
              KEY_RIGHT: begin
                if (cur_r < len_r) cur_nxt = cur_r + AW'(1);
                state_nxt = ST_VS0;
              end
              KEY_BACK: begin
                p_nxt     = cur_r;
                state_nxt = (cur_r == '0) ? ST_DONE : ST_BK_ISS;
              end
              default: begin
                p_nxt = len_r;
                if (len_r < LEN_MAX) begin
                  state_nxt = ST_IN_ISS;
                end else begin
                  ref_nxt   = 1'b1;
                  state_nxt = ST_DONE;
                end
              end
            endcase
          end
        end
      end
      ST_RD0: begin
        raddr_c = addr_ext[AW-1:0];
        // entries at or past the length are zero
        state_nxt = (addr_ext < CW'(len_r)) ? ST_RD1 : ST_DONE;
      end
      ST_RD1: begin
        rd_nxt    = rdata;
        state_nxt = ST_DONE;
      end
      ST_UP0: begin
        p_nxt     = cur_r;
        ret_nxt   = ST_UP1;
        state_nxt = (cur_r == '0) ? ST_VS0 : ST_LB_ISS;
      end
      ST_UP1: begin
        a_nxt   = p_r;
        col_nxt = cur_r - p_r;
        if (p_r == '0) begin
          state_nxt = ST_VS0;
        end else begin
          p_nxt     = p_r - AW'(1);
          ret_nxt   = ST_UP2;
          state_nxt = ST_LB_ISS;
        end
      end
      ST_UP2: begin
        cur_nxt   = p_r + ((col_r > plen_c) ? plen_c : col_r);
        state_nxt = ST_VS0;
      end
      ST_DN0: begin
        p_nxt     = cur_r;
        ret_nxt   = ST_DN1;
        state_nxt = (cur_r >= len_r) ? ST_VS0 : ST_LB_ISS;
      end
      ST_DN1: begin
        col_nxt   = cur_r - p_r;
        p_nxt     = cur_r;
        ret_nxt   = ST_DN2;
        state_nxt = ST_FS_ISS;
      end
      ST_DN2: begin
        if (p_r < len_r) begin
          p_nxt     = p_r + AW'(1);
          a_nxt     = p_r + AW'(1);
          ret_nxt   = ST_DN3;
          state_nxt = ST_FS_ISS;
        end else begin
          cur_nxt   = len_r;
          state_nxt = ST_VS0;
        end
      end
      ST_DN3: begin
        cur_nxt   = a_r + ((col_r > span_c) ? span_c : col_r);
        state_nxt = ST_VS0;
      end
      // scan back to the start of the line holding p
      ST_LB_ISS: begin
        raddr_c = p_r - AW'(1);
        state_nxt = (p_r == '0) ? ret_r : ST_LB_CHK;
      end
      ST_LB_CHK: begin
        if (rdata == NEWLINE) begin
          state_nxt = ret_r;
        end else begin
          p_nxt     = p_r - AW'(1);
          state_nxt = ST_LB_ISS;
        end
      end
      // scan forward to the next newline or the end
      ST_FS_ISS: begin
        state_nxt = (p_r >= len_r) ? ret_r : ST_FS_CHK;
      end
      ST_FS_CHK: begin
        if (rdata == NEWLINE) begin
          state_nxt = ret_r;
        end else begin
          p_nxt     = p_r + AW'(1);
          state_nxt = ST_FS_ISS;
        end
      end
      ST_BK_ISS: begin
        if (p_r >= len_r) begin
          len_nxt   = len_r - AW'(1);
          cur_nxt   = cur_r - AW'(1);
          state_nxt = ST_VS0;
        end else begin
          state_nxt = ST_BK_WR;
        end
      end
      ST_BK_WR: begin
        we_c      = 1'b1;
        waddr_c   = p_r - AW'(1);
        p_nxt     = p_r + AW'(1);
        state_nxt = ST_BK_ISS;
      end
      ST_IN_ISS: begin
        raddr_c = p_r - AW'(1);
        if (p_r == cur_r) begin
          we_c      = 1'b1;
          wdata_c   = key_r;
          len_nxt   = len_r + AW'(1);
          cur_nxt   = cur_r + AW'(1);
          state_nxt = ST_VS0;
        end else begin
          state_nxt = ST_IN_WR;
        end
      end
      ST_IN_WR: begin
        we_c      = 1'b1;
        p_nxt     = p_r - AW'(1);
        state_nxt = ST_IN_ISS;
      end
      ST_VS0: begin
        p_nxt     = '0;
        line_nxt  = '0;
        state_nxt = ST_VS_ISS;
      end
      ST_VS_ISS: begin
        state_nxt = (p_r < cur_r && p_r < len_r) ? ST_VS_CHK : ST_VS_FIX;
      end
      ST_VS_CHK: begin
        if (rdata == NEWLINE) line_nxt = line_r + AW'(1);
        p_nxt     = p_r + AW'(1);
        state_nxt = ST_VS_ISS;
      end
      ST_VS_FIX: begin
        if (line_r < scr_r) begin
          scr_nxt = line_r;
        end else if (SW'(line_r) >= bottom_c) begin
          scr_nxt = AW'(SW'(line_r) - SW'(vis_c) + SW'(1));
        end
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!ov_r || out_if.ready) begin
          ov_nxt    = 1'b1;
          ocur_nxt  = POS_W'(cur_r);
          olen_nxt  = POS_W'(len_r);
          otop_nxt  = POS_W'(scr_r);
          ord_nxt   = rd_r;
          oref_nxt  = ref_r;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ret_r   <= ST_IDLE;
      cur_r   <= '0;
      len_r   <= '0;
      scr_r   <= '0;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ret_r   <= ret_nxt;
      cur_r   <= cur_nxt;
      len_r   <= len_nxt;
      scr_r   <= scr_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_r    <= p_nxt;
    a_r    <= a_nxt;
    col_r  <= col_nxt;
    line_r <= line_nxt;
    key_r  <= key_nxt;
    addr_r <= addr_nxt;
    rd_r   <= rd_nxt;
    ref_r  <= ref_nxt;
    ocur_r <= ocur_nxt;
    olen_r <= olen_nxt;
    otop_r <= otop_nxt;
    ord_r  <= ord_nxt;
    oref_r <= oref_nxt;
  end

  a_cursor_in_text: assert property (@(posedge clk) disable iff (!rst_n)
    cur_r <= len_r) else $error("cursor past end of text");

  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_MAX) else $error("length over store limit");

  a_write_busy: assert property (@(posedge clk) disable iff (!rst_n)
    we_c |-> state_r != ST_IDLE && state_r != ST_DONE)
    else $error("store written outside an edit");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_if.valid && in_if.ready |=> state_r != ST_IDLE)
    else $error("accepted item not started");

  a_refused_full: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DONE && ref_r |-> len_r == LEN_MAX)
    else $error("insert refused with room left");

endmodule
